FILE: rtl/spk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spk_pkg: shared types, constants and round functions
// Word widths, round count, key store addressing and the forward and
// inverse ARX round used by the key schedule and the cipher core.
// ----------------------------------------------------------------------------
package spk_pkg;

  localparam int unsigned ROUNDS    = 32;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned ROT_A     = 8;
  localparam int unsigned ROT_B     = 3;
  localparam int unsigned RK_AW     = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int unsigned CFG_IDX_W = 1;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [RK_AW-1:0]     rk_addr_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam rk_addr_t RK_LAST = rk_addr_t'(ROUNDS - 1);

  typedef enum logic {
    MODE_ENC = 1'b0,
    MODE_DEC = 1'b1
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LOW  = 1'b0,
    REG_KEY_HIGH = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_RUN,
    CORE_HOLD
  } core_state_t;

  // key store write port
  typedef struct packed {
    logic     en;
    rk_addr_t addr;
    word_t    data;
  } rk_wr_t;

  // block halves: x is word one, y is word zero
  typedef struct packed {
    word_t x;
    word_t y;
  } blk_t;

  function automatic word_t rot_r(word_t v, int unsigned r);
    return (v >> r) | (v << (WORD_W - r));
  endfunction

  function automatic word_t rot_l(word_t v, int unsigned r);
    return (v << r) | (v >> (WORD_W - r));
  endfunction

  function automatic blk_t fwd_round(blk_t b, word_t k);
    blk_t r;
    r.x = (rot_r(b.x, ROT_A) + b.y) ^ k;
    r.y = rot_l(b.y, ROT_B) ^ r.x;
    return r;
  endfunction

  function automatic blk_t inv_round(blk_t b, word_t k);
    blk_t r;
    r.y = rot_r(b.y ^ b.x, ROT_B);
    r.x = rot_l((b.x ^ k) - r.y, ROT_A);
    return r;
  endfunction

endpackage

FILE: rtl/spk_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spk_ifs: block and result channels
// Valid/ready channels; a word moves on an edge with valid and ready high.
// ----------------------------------------------------------------------------
interface spk_in_if;
  import spk_pkg::*;
  logic  valid;
  logic  ready;
  logic  mode;
  word_t data_low;
  word_t data_high;
  modport source (output valid, output mode, output data_low, output data_high,
                  input ready);
  modport sink   (input valid, input mode, input data_low, input data_high,
                  output ready);
endinterface

interface spk_out_if;
  import spk_pkg::*;
  logic  valid;
  logic  ready;
  word_t result_low;
  word_t result_high;
  modport source (output valid, output result_low, output result_high,
                  input ready);
  modport sink   (input valid, input result_low, input result_high,
                  output ready);
endinterface

FILE: rtl/spk_key_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spk_key_ram: round key store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module spk_key_ram (
  input  logic              clk,
  input  spk_pkg::rk_wr_t   wr,
  input  spk_pkg::rk_addr_t rd_addr,
  output spk_pkg::word_t    rd_data
);
  import spk_pkg::*;

  word_t mem [ROUNDS];
  word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/spk_key_exp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spk_key_exp: key registers and round key expansion
// Run the schedule one round per cycle into the key store after reset
// and after every key write.
// ----------------------------------------------------------------------------
module spk_key_exp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  spk_pkg::cfg_idx_t cfg_index,
  input  spk_pkg::word_t    cfg_wr_data,
  output spk_pkg::rk_wr_t   rk_wr,
  output logic              busy
);
  import spk_pkg::*;

  word_t    key_low_r,  key_low_nxt;
  word_t    key_high_r, key_high_nxt;
  word_t    a_r, a_nxt;
  word_t    b_r, b_nxt;
  rk_addr_t cnt_r, cnt_nxt;
  logic     busy_r, busy_nxt;
  logic     restart;
  blk_t     cur;
  blk_t     step;

  always_comb begin
    key_low_nxt  = key_low_r;
    key_high_nxt = key_high_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    cnt_nxt      = cnt_r;
    busy_nxt     = busy_r;
    restart      = 1'b0;
    cur.x        = b_r;
    cur.y        = a_r;
    step         = fwd_round(cur, word_t'(cnt_r));

    if (busy_r) begin
      a_nxt   = step.y;
      b_nxt   = step.x;
      cnt_nxt = rk_addr_t'(cnt_r + 1'b1);
      if (cnt_r == RK_LAST) begin
        busy_nxt = 1'b0;
      end
    end

    if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_KEY_LOW: begin
          key_low_nxt = cfg_wr_data;
          restart     = 1'b1;
        end
        REG_KEY_HIGH: begin
          key_high_nxt = cfg_wr_data;
          restart      = 1'b1;
        end
        default: ;
      endcase
    end

    // start over from the key words
    if (restart) begin
      a_nxt    = key_low_nxt;
      b_nxt    = key_high_nxt;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
      a_r        <= '0;
      b_r        <= '0;
      cnt_r      <= '0;
      busy_r     <= 1'b1;
    end else begin
      key_low_r  <= key_low_nxt;
      key_high_r <= key_high_nxt;
      a_r        <= a_nxt;
      b_r        <= b_nxt;
      cnt_r      <= cnt_nxt;
      busy_r     <= busy_nxt;
    end
  end

  assign rk_wr.en   = busy_r;
  assign rk_wr.addr = cnt_r;
  assign rk_wr.data = a_r;
  assign busy       = busy_r;

  a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> busy_r && (cnt_r == '0))
    else $error("key write did not restart expansion");

  a_full_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> ($past(cnt_r) == RK_LAST))
    else $error("expansion ended before the last round key");

  a_cnt_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !cfg_wr_en && (cnt_r != RK_LAST)) |=>
      (cnt_r == rk_addr_t'($past(cnt_r) + 1'b1)))
    else $error("expansion counter skipped");

endmodule

FILE: rtl/spk_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spk_core: cipher round engine
// One ARX round per cycle, each round key addressed in the store the cycle
// before its round; result goes to an output register.
// ----------------------------------------------------------------------------
module spk_core (
  input  logic              clk,
  input  logic              rst_n,
  spk_in_if.sink            in_ch,
  spk_out_if.source         out_ch,
  input  logic              exp_busy,
  output spk_pkg::rk_addr_t rd_addr,
  input  spk_pkg::word_t    rd_data
);
  import spk_pkg::*;

  core_state_t state_r, state_nxt;
  rk_addr_t    cnt_r, cnt_nxt;
  mode_t       mode_r, mode_nxt;
  blk_t        blk_r, blk_nxt;
  logic        out_valid_r, out_valid_nxt;
  blk_t        out_blk_r, out_blk_nxt;
  logic        accept;
  logic        out_free;
  blk_t        rnd;

  assign in_ch.ready = (state_r == CORE_IDLE) && !exp_busy;
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  always_comb begin
    if (mode_r == MODE_DEC) begin
      rnd = inv_round(blk_r, rd_data);
    end else begin
      rnd = fwd_round(blk_r, rd_data);
    end
  end

  // key for the next round; decrypt walks the store downward
  always_comb begin
    if (accept) begin
      rd_addr = (mode_t'(in_ch.mode) == MODE_DEC) ? RK_LAST : '0;
    end else if (mode_r == MODE_DEC) begin
      rd_addr = rk_addr_t'(RK_LAST - cnt_r - 1'b1);
    end else begin
      rd_addr = rk_addr_t'(cnt_r + 1'b1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    mode_nxt      = mode_r;
    blk_nxt       = blk_r;
    out_blk_nxt   = out_blk_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      CORE_IDLE: begin
        if (accept) begin
          blk_nxt.x = in_ch.data_high;
          blk_nxt.y = in_ch.data_low;
          mode_nxt  = mode_t'(in_ch.mode);
          cnt_nxt   = '0;
          state_nxt = CORE_RUN;
        end
      end
      CORE_RUN: begin
        blk_nxt = rnd;
        cnt_nxt = rk_addr_t'(cnt_r + 1'b1);
        if (cnt_r == RK_LAST) begin
          if (out_free) begin
            out_blk_nxt   = rnd;
            out_valid_nxt = 1'b1;
            state_nxt     = CORE_IDLE;
          end else begin
            state_nxt = CORE_HOLD;
          end
        end
      end
      CORE_HOLD: begin
        if (out_free) begin
          out_blk_nxt   = blk_r;
          out_valid_nxt = 1'b1;
          state_nxt     = CORE_IDLE;
        end
      end
      default: begin
        state_nxt = CORE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CORE_IDLE;
      cnt_r       <= '0;
      mode_r      <= MODE_ENC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r     <= blk_nxt;
    out_blk_r <= out_blk_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_low  = out_blk_r.y;
  assign out_ch.result_high = out_blk_r.x;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == CORE_RUN) && (cnt_r == '0))
    else $error("accepted word did not start a run");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == CORE_RUN) && (cnt_r == RK_LAST)) |=> (state_r != CORE_RUN))
    else $error("run went past the last round");

  a_hold_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CORE_HOLD) |-> out_valid_r)
    else $error("result held with the output register empty");

  a_no_run_in_exp: assert property (@(posedge clk) disable iff (!rst_n)
    exp_busy |-> !accept)
    else $error("word accepted during key expansion");

endmodule

FILE: rtl/speck_block_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// speck_block_cipher: Speck128/128 encrypt/decrypt engine
// Round keys are expanded into a key store; one ARX round per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one word per block: mode (0 encrypt, 1 decrypt), data_low (y),
//            data_high (x).
//   out_ch : one word per block: result_low (y), result_high (x).
//   cfg    : write key_low (index 0) or key_high (index 1) with cfg_wr_en;
//            write only while the engine is idle.
// Timing:
//   An accepted block runs one round per cycle through the single round
//   unit, each round key read ahead from the key store's registered port,
//   and then shows out_ch.valid.
//   A new block is taken the cycle after the result is loaded, so the
//   engine works on one block at a time.
// Reset and key load:
//   After reset, and after each key write, the schedule fills the key
//   store round by round; in_ch.ready stays low meanwhile.
// Stall:
//   The result waits in an output register; a new block may be accepted
//   and processed behind it. If that block finishes while the register is
//   still full, the engine holds it and takes no new word until out_ch
//   drains.
// ----------------------------------------------------------------------------
module speck_block_cipher (
  input  logic              clk,
  input  logic              rst_n,
  spk_in_if.sink            in_ch,
  spk_out_if.source         out_ch,
  input  logic              cfg_wr_en,
  input  spk_pkg::cfg_idx_t cfg_index,
  input  spk_pkg::word_t    cfg_wr_data
);
  import spk_pkg::*;

  rk_wr_t   rk_wr;
  logic     exp_busy;
  rk_addr_t rk_rd_addr;
  word_t    rk_rd_data;

  // key registers and schedule: writes the store after reset / key writes
  spk_key_exp u_key_exp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .rk_wr       (rk_wr),
    .busy        (exp_busy)
  );

  // key store: schedule writes, core reads; user, not block, keeps them apart
  spk_key_ram u_key_ram (
    .clk     (clk),
    .wr      (rk_wr),
    .rd_addr (rk_rd_addr),
    .rd_data (rk_rd_data)
  );

  // round engine and output register
  spk_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .exp_busy (exp_busy),
    .rd_addr  (rk_rd_addr),
    .rd_data  (rk_rd_data)
  );

endmodule

FILE: tb/sv/speck_block_cipher_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// speck_block_cipher_test: self-checking bench for the Speck128/128 engine
// Drives blocks through the input channel with random gaps and checks each
// result word against an in-bench cipher model keyed from the same writes.
// ----------------------------------------------------------------------------
module speck_block_cipher_test;
  import spk_pkg::*;

  // one block offered on the input channel
  typedef struct {
    mode_t mode;
    word_t lo;
    word_t hi;
  } plain_item_t;

  // one result word as the model predicts it
  typedef struct {
    word_t lo;
    word_t hi;
  } cipher_out_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  cfg_idx_t cfg_index;
  word_t cfg_wr_data;

  spk_in_if  in_ch ();
  spk_out_if out_ch ();

  speck_block_cipher u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  // Model state: key words as last written and the round keys built from them.
  word_t key_lo_model = '0;
  word_t key_hi_model = '0;
  word_t key_sched [ROUNDS];

  plain_item_t blocks_to_send [$];   // waiting for the driver
  cipher_out_t expected_blocks [$];  // predicted, waiting for the result side
  plain_item_t in_flight;            // word currently offered on in_ch

  int unsigned errors          = 0;
  int unsigned blocks_accepted = 0;
  int unsigned enc_blocks      = 0;
  int unsigned dec_blocks      = 0;
  int unsigned results_seen    = 0;
  int unsigned key_writes      = 0;
  int unsigned src_gap         = 0;
  int unsigned sink_gap        = 0;

  logic idle_on  = 1'b1;  // random gaps on both channels
  logic hold_off = 1'b0;  // long receiver stall

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------

  // Rebuild the round keys: run the forward round on the key words with the
  // round number standing in for the round key.
  function automatic void expand_key_sched();
    word_t a;
    word_t b;
    a = key_lo_model;
    b = key_hi_model;
    for (int r = 0; r < ROUNDS; r++) begin
      key_sched[r] = a;
      b = ({b[ROT_A-1:0], b[WORD_W-1:ROT_A]} + a) ^ word_t'(r);
      a = {a[WORD_W-ROT_B-1:0], a[WORD_W-1:WORD_W-ROT_B]} ^ b;
    end
  endfunction

  // Encrypt runs the rounds forward; decrypt undoes them last key first.
  function automatic cipher_out_t speck_predict(plain_item_t blk);
    word_t x;
    word_t y;
    word_t t;
    cipher_out_t res;
    x = blk.hi;
    y = blk.lo;
    if (blk.mode == MODE_ENC) begin
      for (int r = 0; r < ROUNDS; r++) begin
        x = ({x[ROT_A-1:0], x[WORD_W-1:ROT_A]} + y) ^ key_sched[r];
        y = {y[WORD_W-ROT_B-1:0], y[WORD_W-1:WORD_W-ROT_B]} ^ x;
      end
    end else begin
      for (int r = ROUNDS - 1; r >= 0; r--) begin
        t = y ^ x;
        y = {t[ROT_B-1:0], t[WORD_W-1:ROT_B]};
        t = (x ^ key_sched[r]) - y;
        x = {t[WORD_W-ROT_A-1:0], t[WORD_W-1:WORD_W-ROT_A]};
      end
    end
    res.lo = y;
    res.hi = x;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------

  // Count every failure; print only the first ten.
  function automatic void flag_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Mostly dense random words, with zeros, ones and single-bit patterns mixed in.
  function automatic word_t rand_word();
    word_t w;
    case ($urandom_range(0, 9))
      0: w = '0;
      1: w = '1;
      2: w = word_t'(1) << $urandom_range(0, WORD_W - 1);
      3: w = ~(word_t'(1) << $urandom_range(0, WORD_W - 1));
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  function automatic void queue_block(mode_t m, word_t lo, word_t hi);
    plain_item_t blk;
    blk.mode = m;
    blk.lo   = lo;
    blk.hi   = hi;
    blocks_to_send.push_back(blk);
  endfunction

  // Random blocks under the current key. About one in five becomes a round
  // trip: an encrypt followed by the decrypt of its predicted ciphertext.
  function automatic void queue_random_blocks(int unsigned n);
    plain_item_t blk;
    cipher_out_t ct;
    int unsigned k;
    k = 0;
    while (k < n) begin
      blk.lo = rand_word();
      blk.hi = rand_word();
      if ($urandom_range(0, 4) == 0) begin
        blk.mode = MODE_ENC;
        blocks_to_send.push_back(blk);
        ct = speck_predict(blk);
        queue_block(MODE_DEC, ct.lo, ct.hi);
        k += 2;
      end else begin
        blk.mode = mode_t'($urandom_range(0, 1));
        blocks_to_send.push_back(blk);
        k++;
      end
    end
  endfunction

  // Block until the engine has nothing queued, offered or owed.
  task automatic wait_idle();
    while (blocks_to_send.size() != 0 || in_ch.valid || expected_blocks.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // One-cycle key register write; only called with the engine idle, so the
  // model is updated right away.
  task automatic write_key(cfg_reg_t idx, word_t val);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    if (idx == REG_KEY_LOW) key_lo_model = val;
    else key_hi_model = val;
    expand_key_sched();
    key_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Driver: offer queued blocks, hold each until it is taken, and push the
  // prediction on the edge that accepts it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_blocks.push_back(speck_predict(in_flight));
        blocks_accepted++;
        if (in_flight.mode == MODE_DEC) dec_blocks++;
        else enc_blocks++;
      end
      // Only change what is offered once the current word is gone.
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap == 0 && idle_on && $urandom_range(0, 7) == 0)
          src_gap = $urandom_range(1, 6);
        if (src_gap > 0) begin
          src_gap--;
          in_ch.valid <= 1'b0;
        end else if (blocks_to_send.size() != 0) begin
          in_flight = blocks_to_send.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.mode      <= in_flight.mode;
          in_ch.data_low  <= in_flight.lo;
          in_ch.data_high <= in_flight.hi;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each accepted result against the oldest prediction, and
  // throttle ready with random bursts or the long hold-off.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    cipher_out_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_blocks.size() == 0) begin
          flag_error($sformatf("result with nothing expected: low %h high %h",
                               out_ch.result_low, out_ch.result_high));
        end else begin
          want = expected_blocks.pop_front();
          if (out_ch.result_low !== want.lo)
            flag_error($sformatf("result_low: expected %h, got %h",
                                 want.lo, out_ch.result_low));
          if (out_ch.result_high !== want.hi)
            flag_error($sformatf("result_high: expected %h, got %h",
                                 want.hi, out_ch.result_high));
        end
      end
      if (sink_gap == 0 && idle_on && $urandom_range(0, 7) == 0)
        sink_gap = $urandom_range(1, 6);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long receiver stall: once the random traffic is well under way, drop
  // ready through the hold-off. The sender keeps offering, so the output register
  // and the held block fill and in_ch.ready must go low.
  // --------------------------------------------------------------------------
  initial begin
    wait (blocks_accepted >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (150) @(posedge clk);
    hold_off <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Run limit: far beyond the slowest legal run.
  // --------------------------------------------------------------------------
  initial begin
    #16_000_000;
    $display("speck_block_cipher verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    // Known values on every input from time zero.
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_index       = REG_KEY_LOW;
    cfg_wr_data     = '0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = MODE_ENC;
    in_ch.data_low  = '0;
    in_ch.data_high = '0;
    out_ch.ready    = 1'b0;
    expand_key_sched();  // reset key is all zero

    // Synchronous reset; the engine then loads the zero-key schedule and
    // keeps in_ch.ready low until it is done, which the driver waits out.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed blocks under the reset key: zero, all ones, and the corner
    // bits of each half, in both directions.
    for (int m = 0; m < 2; m++) begin
      queue_block(mode_t'(m), '0, '0);
      queue_block(mode_t'(m), '1, '1);
      queue_block(mode_t'(m), word_t'(1), '0);
      queue_block(mode_t'(m), '0, word_t'(1));
      queue_block(mode_t'(m), {1'b1, {(WORD_W-1){1'b0}}}, '0);
      queue_block(mode_t'(m), '0, {1'b1, {(WORD_W-1){1'b0}}});
    end
    wait_idle();

    // Published Speck128/128 vector: encrypt the plaintext and decrypt the
    // ciphertext, plus the extreme blocks under this key.
    write_key(REG_KEY_LOW,  64'h0706050403020100);
    write_key(REG_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
    queue_block(MODE_ENC, 64'h7469206564616d20, 64'h6c61766975716520);
    queue_block(MODE_DEC, 64'h7860fedf5c570d18, 64'ha65d985179783265);
    queue_block(MODE_ENC, '1, '1);
    queue_block(MODE_DEC, '0, '0);
    wait_idle();

    // Random traffic under a run of key settings: both words at the top,
    // each word alone at zero, then random keys. Single writes show that
    // changing either register rebuilds the whole schedule.
    write_key(REG_KEY_LOW,  '1);
    write_key(REG_KEY_HIGH, '1);
    queue_random_blocks(256);
    wait_idle();

    write_key(REG_KEY_HIGH, '0);
    queue_random_blocks(256);   // long stall lands in here
    wait_idle();

    write_key(REG_KEY_LOW,  '0);
    write_key(REG_KEY_HIGH, '1);
    queue_random_blocks(256);
    wait_idle();

    write_key(REG_KEY_LOW,  {$urandom, $urandom});
    write_key(REG_KEY_HIGH, {$urandom, $urandom});
    queue_random_blocks(256);
    wait_idle();

    write_key(REG_KEY_HIGH, {$urandom, $urandom});
    write_key(REG_KEY_LOW,  {$urandom, $urandom});
    queue_random_blocks(256);
    wait_idle();

    // Last stretch at full rate on both sides.
    @(posedge clk);
    idle_on <= 1'b0;
    write_key(REG_KEY_LOW, {$urandom, $urandom});
    queue_random_blocks(256);
    wait_idle();

    // Let any stray result surface before the verdict.
    repeat (40) @(posedge clk);

    $display("Covered %0d encrypt and %0d decrypt blocks over %0d key writes,",
             enc_blocks, dec_blocks, key_writes);
    $display("%0d results checked, including a 150-cycle receiver stall.", results_seen);
    if (errors == 0) begin
      $display("speck_block_cipher verification clean");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("speck_block_cipher verification failed");
    end
    $finish;
  end

endmodule
